[sv/sorted_priority_queue_core_macros.svh]
// Assertion macros for the sorted priority queue checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/spq_pkg.sv]
// Shared constants, codes and types of the sorted priority queue.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int ID_WIDTH_DEF   = 16;
	localparam int PRIO_WIDTH_DEF = 16;

	localparam logic [1:0] ACT_JOIN   = 2'd0;
	localparam logic [1:0] ACT_LEAVE  = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// Update command broadcast to every cell.
	typedef struct packed {
		logic en;
		logic rm;
		logic ins;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[sv/spq_ifs.sv]
// Valid/ready channel interfaces for the sorted priority queue.
// No dependencies.
`default_nettype none

interface spq_req_if #(
	parameter int ID_WIDTH   = 16,
	parameter int PRIO_WIDTH = 16
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [ID_WIDTH-1:0]   item_id;
	logic [PRIO_WIDTH-1:0] item_priority;

	modport source (output valid, action, item_id, item_priority, input ready);
	modport sink   (input valid, action, item_id, item_priority, output ready);
endinterface

interface spq_rsp_if #(
	parameter int ID_WIDTH  = 16,
	parameter int CNT_WIDTH = 7
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [ID_WIDTH-1:0]  left_id;
	logic                 found;
	logic [ID_WIDTH-1:0]  head_id;
	logic                 not_empty;
	logic [CNT_WIDTH-1:0] entry_count;

	modport source (output valid, status, left_id, found, head_id, not_empty, entry_count,
		input ready);
	modport sink   (input valid, status, left_id, found, head_id, not_empty, entry_count,
		output ready);
endinterface

`default_nettype wire

[sv/spq_cell.sv]
// One slot of the sorted list: holds an entry, compares it against the
// incoming beat and shifts with its neighbors. Uses spq_pkg.
`default_nettype none

module spq_cell #(
	parameter int INDEX      = 0,
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH   = spq_pkg::ID_WIDTH_DEF,
	parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic [$clog2(DEPTH+1)-1:0] count,
	input  wire logic [ID_WIDTH-1:0]       cmp_id,
	input  wire logic [PRIO_WIDTH-1:0]     cmp_prio,
	output      logic                      match,
	output      logic                      le,
	input  wire spq_pkg::cell_ctrl_t       ctrl,
	input  wire logic [$clog2(DEPTH)-1:0]  rm_idx,
	input  wire logic [$clog2(DEPTH+1)-1:0] ins_pos,
	input  wire logic [ID_WIDTH-1:0]       new_id,
	input  wire logic [PRIO_WIDTH-1:0]     new_prio,
	input  wire logic [ID_WIDTH-1:0]       prev_id,
	input  wire logic [PRIO_WIDTH-1:0]     prev_prio,
	input  wire logic [ID_WIDTH-1:0]       next_id,
	input  wire logic [PRIO_WIDTH-1:0]     next_prio,
	output      logic [ID_WIDTH-1:0]       id,
	output      logic [PRIO_WIDTH-1:0]     prio,
	output      logic [ID_WIDTH-1:0]       nxt_id
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam logic [IW-1:0] IDX_I  = IW'(INDEX);
	localparam logic [CW-1:0] IDX_C  = CW'(INDEX);
	localparam logic          HAS_PREV = (INDEX > 0);
	localparam logic [IW-1:0] PREV_I = IW'((INDEX > 0) ? INDEX - 1 : 0);

	logic [ID_WIDTH-1:0]   id_q;
	logic [PRIO_WIDTH-1:0] prio_q;
	logic                  live;
	logic                  take_next;
	logic                  self_from_prev;
	logic [ID_WIDTH-1:0]   rs_id, rp_id;
	logic [PRIO_WIDTH-1:0] rs_prio, rp_prio;
	logic [PRIO_WIDTH-1:0] nxt_prio;

	assign live  = IDX_C < count;
	assign match = live && (id_q == cmp_id);
	assign le    = live && (prio_q <= cmp_prio);

	// Removal view: what this slot and the slot above hold once the
	// removed entry has closed its gap.
	assign take_next      = ctrl.rm && (IDX_I >= rm_idx);
	assign self_from_prev = HAS_PREV && ctrl.rm && (PREV_I >= rm_idx);
	assign rs_id   = take_next ? next_id : id_q;
	assign rs_prio = take_next ? next_prio : prio_q;
	assign rp_id   = self_from_prev ? id_q : prev_id;
	assign rp_prio = self_from_prev ? prio_q : prev_prio;

	always_comb begin
		nxt_id   = rs_id;
		nxt_prio = rs_prio;
		if (ctrl.ins) begin
			if (IDX_C == ins_pos) begin
				nxt_id   = new_id;
				nxt_prio = new_prio;
			end else if (IDX_C > ins_pos) begin
				nxt_id   = rp_id;
				nxt_prio = rp_prio;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			id_q   <= nxt_id;
			prio_q <= nxt_prio;
		end
	end

	assign id   = id_q;
	assign prio = prio_q;

endmodule

`default_nettype wire

[sv/spq_scan.sv]
// Reduces the per-cell compare flags to the match position and the
// number of entries at or below the incoming priority. Uses spq_pkg.
`default_nettype none

module spq_scan #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic [DEPTH-1:0]           match,
	input  wire logic [DEPTH-1:0]           le,
	output      logic                       found,
	output      logic [$clog2(DEPTH)-1:0]   m_idx,
	output      logic [$clog2(DEPTH+1)-1:0] q_cnt
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [DEPTH-1:0] edge_v;

	// le is a prefix over the sorted live slots: mark its last set slot.
	always_comb begin
		edge_v[DEPTH-1] = le[DEPTH-1];
		for (int k = 0; k < DEPTH - 1; k++) begin
			edge_v[k] = le[k] & ~le[k+1];
		end
	end

	always_comb begin
		m_idx = '0;
		q_cnt = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (match[k]) begin
				m_idx = m_idx | IW'(k);
			end
			if (edge_v[k]) begin
				q_cnt = q_cnt | CW'(k + 1);
			end
		end
	end

	assign found = |match;

endmodule

`default_nettype wire

[sv/sorted_priority_queue_core.sv]
// Sorted priority queue built as a chain of entry cells.
// Uses spq_pkg, spq_ifs (spq_req_if, spq_rsp_if), spq_cell and spq_scan.
//
//   channel  dir  payload                                                  beat
//   req      in   action, item_id, item_priority                           valid & ready
//   rsp      out  status, left_id, found, head_id, not_empty, entry_count  valid & ready
//
// The accept cycle compares each beat against every cell and registers the
// match and insert positions; the apply state then shifts the chain.
// req takes one beat at a time; ready is high only between items.
// The apply cycle holds while the previous result still sits unread on rsp.
// arst_n empties the queue at once; cell contents are not cleared.
`default_nettype none

module sorted_priority_queue_core #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH   = spq_pkg::ID_WIDTH_DEF,
	parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_APPLY = 1'b1;

	logic state_q;
	logic [CW-1:0] count_q;

	logic [DEPTH-1:0]      match_v, le_v;
	logic [ID_WIDTH-1:0]   id_v [DEPTH];
	logic [PRIO_WIDTH-1:0] prio_v [DEPTH];
	logic [ID_WIDTH-1:0]   nxt_id_v [DEPTH];

	logic          scan_found;
	logic [IW-1:0] scan_m;
	logic [CW-1:0] scan_q;

	logic [1:0]            act_s1;
	logic [ID_WIDTH-1:0]   id_s1;
	logic [PRIO_WIDTH-1:0] prio_s1;
	logic                  found_s1;
	logic [IW-1:0]         m_s1;
	logic [CW-1:0]         q_s1;

	logic                  accept;
	logic                  apply_go;
	spq_pkg::cell_ctrl_t   ctrl;
	logic [IW-1:0]         rm_idx;
	logic [CW-1:0]         ins_pos;
	logic [1:0]            status;
	logic                  found;
	logic [ID_WIDTH-1:0]   left_id;
	logic [CW-1:0]         count_nxt;

	logic                  rsp_valid_q;
	logic [1:0]            status_q;
	logic [ID_WIDTH-1:0]   left_id_q;
	logic                  found_q;
	logic [ID_WIDTH-1:0]   head_id_q;
	logic [CW-1:0]         count_out_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign apply_go  = (state_q == ST_APPLY) && (!rsp_valid_q || rsp.ready);

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		localparam int PJ = (j > 0) ? j - 1 : 0;
		localparam int NJ = (j < DEPTH - 1) ? j + 1 : j;
		spq_cell #(
			.INDEX      (j),
			.DEPTH      (DEPTH),
			.ID_WIDTH   (ID_WIDTH),
			.PRIO_WIDTH (PRIO_WIDTH)
		) u_cell (
			.clk       (clk),
			.count     (count_q),
			.cmp_id    (req.item_id),
			.cmp_prio  (req.item_priority),
			.match     (match_v[j]),
			.le        (le_v[j]),
			.ctrl      (ctrl),
			.rm_idx    (rm_idx),
			.ins_pos   (ins_pos),
			.new_id    (id_s1),
			.new_prio  (prio_s1),
			.prev_id   (id_v[PJ]),
			.prev_prio (prio_v[PJ]),
			.next_id   (id_v[NJ]),
			.next_prio (prio_v[NJ]),
			.id        (id_v[j]),
			.prio      (prio_v[j]),
			.nxt_id    (nxt_id_v[j])
		);
	end

	spq_scan #(.DEPTH(DEPTH)) u_scan (
		.match (match_v),
		.le    (le_v),
		.found (scan_found),
		.m_idx (scan_m),
		.q_cnt (scan_q)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= req.action;
			id_s1    <= req.item_id;
			prio_s1  <= req.item_priority;
			found_s1 <= scan_found;
			m_s1     <= scan_m;
			q_s1     <= scan_q;
		end
	end

	// Decide the shift for this beat.
	always_comb begin
		ctrl.rm = 1'b0;
		ctrl.ins = 1'b0;
		rm_idx  = m_s1;
		ins_pos = q_s1;
		status  = spq_pkg::STAT_OK;
		found   = 1'b0;
		left_id = '0;
		case (act_s1)
			spq_pkg::ACT_JOIN: begin
				found = found_s1;
				if (found_s1) begin
					// Reprioritize: the old entry drops out ahead of the insert point.
					ctrl.rm  = 1'b1;
					ctrl.ins = 1'b1;
					ins_pos  = q_s1 - CW'(CW'(m_s1) < q_s1);
				end else if (count_q == FULL_CNT) begin
					status = spq_pkg::STAT_FULL;
				end else begin
					ctrl.ins = 1'b1;
				end
			end
			spq_pkg::ACT_LEAVE: begin
				if (count_q == '0) begin
					status = spq_pkg::STAT_EMPTY;
				end else begin
					ctrl.rm = 1'b1;
					rm_idx  = '0;
					left_id = id_v[0];
				end
			end
			spq_pkg::ACT_LOOKUP: begin
				found = found_s1;
			end
			default: begin
			end
		endcase
		ctrl.en   = apply_go && (ctrl.rm || ctrl.ins);
		count_nxt = count_q - CW'(ctrl.rm) + CW'(ctrl.ins);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (apply_go) begin
						state_q <= ST_IDLE;
						count_q <= count_nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			status_q    <= status;
			left_id_q   <= left_id;
			found_q     <= found;
			head_id_q   <= (count_nxt != '0) ? nxt_id_v[0] : '0;
			count_out_q <= count_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.left_id     = left_id_q;
	assign rsp.found       = found_q;
	assign rsp.head_id     = head_id_q;
	assign rsp.not_empty   = (count_out_q != '0);
	assign rsp.entry_count = count_out_q;

endmodule

`default_nettype wire

[sv/spq_checker.sv]
// Port-level checks on the result channel of the sorted priority queue.
// Uses spq_pkg and sorted_priority_queue_core_macros.svh; bound to the top level.
`default_nettype none

`include "sorted_priority_queue_core_macros.svh"

module spq_checker #(
	parameter int DEPTH    = spq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH = spq_pkg::ID_WIDTH_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [1:0]                 status,
	input wire logic [ID_WIDTH-1:0]        left_id,
	input wire logic                       found,
	input wire logic                       not_empty,
	input wire logic [$clog2(DEPTH+1)-1:0] entry_count
);

	localparam int CW = $clog2(DEPTH+1);

	`SPQ_ASSERT_IMPL(a_count_range, rsp_valid, entry_count <= CW'(DEPTH), "count above depth")
	`SPQ_ASSERT_IMPL(a_not_empty, rsp_valid, not_empty == (entry_count != '0), "not_empty mismatch")
	`SPQ_ASSERT_IMPL(a_empty_leave, rsp_valid && status == spq_pkg::STAT_EMPTY, entry_count == '0 && left_id == '0 && !found, "bad empty leave")
	`SPQ_ASSERT_IMPL(a_full_join, rsp_valid && status == spq_pkg::STAT_FULL, entry_count == CW'(DEPTH) && !found, "bad full drop")
	`SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(entry_count), "result dropped")

endmodule

bind sorted_priority_queue_core spq_checker #(
	.DEPTH    (DEPTH),
	.ID_WIDTH (ID_WIDTH)
) u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.left_id     (rsp.left_id),
	.found       (rsp.found),
	.not_empty   (rsp.not_empty),
	.entry_count (rsp.entry_count)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_core: joins, leaves and lookups
// are mirrored in a scoreboard class and every response beat is compared.
// Depends on spq_pkg, spq_ifs and the block itself.

import spq_pkg::*;

typedef logic [ID_WIDTH_DEF-1:0]   id_t;
typedef logic [PRIO_WIDTH_DEF-1:0] prio_t;

typedef struct packed {
	id_t   id;
	prio_t prio;
} slot_t;

typedef struct packed {
	logic [1:0] status;
	id_t        left_id;
	logic       found;
	id_t        head_id;
	logic       not_empty;
	logic [6:0] entry_count;
} outcome_t;

class spq_scoreboard;
	slot_t    held[$];
	outcome_t outcomes_due[$];
	int       mismatches;
	int       checked;
	int       n_join, n_reprio, n_full, n_leave, n_empty, n_lookup, n_hit, n_idle_act;
	int       peak;

	function int find_id(id_t id);
		for (int i = 0; i < held.size(); i++)
			if (held[i].id == id) return i;
		return -1;
	endfunction

	// Insert behind every entry of lower or equal priority.
	function void place(id_t id, prio_t prio);
		slot_t s;
		int    pos;
		s.id = id;
		s.prio = prio;
		pos = 0;
		while (pos < held.size() && held[pos].prio <= prio) pos++;
		held.insert(pos, s);
	endfunction

	function id_t any_held();
		return held[$urandom_range(0, held.size() - 1)].id;
	endfunction

	function void note_request(logic [1:0] act, id_t id, prio_t prio);
		outcome_t o;
		int       pos;
		o = '0;
		pos = find_id(id);
		case (act)
			ACT_JOIN: begin
				n_join++;
				if (pos >= 0) begin
					o.found = 1'b1;
					n_reprio++;
					held.delete(pos);
					place(id, prio);
				end else if (held.size() >= DEPTH_DEF) begin
					o.status = STAT_FULL;
					n_full++;
				end else begin
					place(id, prio);
				end
			end
			ACT_LEAVE: begin
				n_leave++;
				if (held.size() == 0) begin
					o.status = STAT_EMPTY;
					n_empty++;
				end else begin
					o.left_id = held[0].id;
					void'(held.pop_front());
				end
			end
			ACT_LOOKUP: begin
				n_lookup++;
				o.found = (pos >= 0);
				if (pos >= 0) n_hit++;
			end
			default: n_idle_act++;
		endcase
		if (held.size() > 0) begin
			o.head_id = held[0].id;
			o.not_empty = 1'b1;
		end
		o.entry_count = 7'(held.size());
		if (held.size() > peak) peak = held.size();
		outcomes_due.push_back(o);
	endfunction

	function void check_outcome(outcome_t got);
		outcome_t want;
		checked++;
		if (outcomes_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] response %0d with nothing expected", $time, checked);
				$display("  actual   status=%0d left=%h found=%0d head=%h nonempty=%0d count=%0d",
					got.status, got.left_id, got.found, got.head_id,
					got.not_empty, got.entry_count);
			end
			return;
		end
		want = outcomes_due.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] response %0d mismatch", $time, checked);
				$display("  expected status=%0d left=%h found=%0d head=%h nonempty=%0d count=%0d",
					want.status, want.left_id, want.found, want.head_id, want.not_empty,
					want.entry_count);
				$display("  actual   status=%0d left=%h found=%0d head=%h nonempty=%0d count=%0d",
					got.status, got.left_id, got.found, got.head_id, got.not_empty,
					got.entry_count);
			end
		end
	endfunction
endclass

module tb;
	localparam int LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1035;
	localparam int LONG_HOLD = 400;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef enum int {MIX_FILL, MIX_BLEND, MIX_DRAIN} mix_t;

	logic clk;
	logic arst_n;
	int   cycles;
	bit   hold_request;
	bit   calm;

	spq_scoreboard sb = new;

	spq_req_if #(.ID_WIDTH(ID_WIDTH_DEF), .PRIO_WIDTH(PRIO_WIDTH_DEF)) req_ch ();
	spq_rsp_if #(.ID_WIDTH(ID_WIDTH_DEF), .CNT_WIDTH(7)) rsp_ch ();

	sorted_priority_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic id_t pick_id(bit prefer_held);
		int r;
		r = $urandom_range(0, 99);
		if (prefer_held && sb.held.size() > 0 && r < 35) return sb.any_held();
		if (r < 70) return id_t'($urandom);
		if (r < 95) return id_t'($urandom_range(0, 31));
		return r[0] ? '1 : '0;
	endfunction

	function automatic prio_t pick_prio();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return prio_t'($urandom_range(0, 7));
		if (r < 80) return prio_t'($urandom);
		if (r < 90) return '0;
		return '1;
	endfunction

	task automatic send_item(input logic [1:0] act, input id_t id, input prio_t prio);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.item_id <= id;
		req_ch.item_priority <= prio;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(act, id, prio);
	endtask

	task automatic random_item(input mix_t mix);
		int r;
		int join_pct;
		int leave_pct;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  begin join_pct = 85; leave_pct = 5;  end
			MIX_BLEND: begin join_pct = 45; leave_pct = 35; end
			default:   begin join_pct = 10; leave_pct = 75; end
		endcase
		if (r == 99)
			send_item(ACT_NONE, pick_id(1'b0), pick_prio());
		else if (r < join_pct)
			send_item(ACT_JOIN, pick_id(1'b1), pick_prio());
		else if (r < join_pct + leave_pct)
			send_item(ACT_LEAVE, pick_id(1'b0), pick_prio());
		else
			send_item(ACT_LOOKUP, pick_id(1'b1), pick_prio());
	endtask

	// Response side: check each beat, stall at random or on request.
	initial begin
		int       stall;
		bit       hold_taken;
		outcome_t got;
		stall = 0;
		hold_taken = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.left_id = rsp_ch.left_id;
				got.found = rsp_ch.found;
				got.head_id = rsp_ch.head_id;
				got.not_empty = rsp_ch.not_empty;
				got.entry_count = rsp_ch.entry_count;
				sb.check_outcome(got);
			end
			if (hold_request && !hold_taken) begin
				stall = LONG_HOLD;
				hold_taken = 1'b1;
			end else if (stall == 0 && !calm && $urandom_range(0, 99) < 25) begin
				stall = gap_len();
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycles,
			sb.outcomes_due.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		mix_t mix;
		int   done;
		int   span;
		int   phase;
		arst_n = 1'b0;
		hold_request = 1'b0;
		calm = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_JOIN;
		req_ch.item_id = '0;
		req_ch.item_priority = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Empty queue: leave, lookup and the unused action.
		send_item(ACT_LEAVE, '0, '0);
		send_item(ACT_LOOKUP, '0, '0);
		send_item(ACT_NONE, '0, '0);
		// Extremes of id and priority, then a tie at priority zero.
		send_item(ACT_JOIN, '0, '1);
		send_item(ACT_JOIN, '1, '0);
		send_item(ACT_JOIN, 16'h1234, '0);
		send_item(ACT_LOOKUP, '1, 16'h5555);
		send_item(ACT_LOOKUP, 16'hAAAA, '0);
		// Reprioritize: id zero moves behind both entries at priority zero.
		send_item(ACT_JOIN, '0, '0);
		send_item(ACT_JOIN, 16'h1234, '1);
		send_item(ACT_NONE, 16'hFFFF, '1);
		send_item(ACT_JOIN, 16'h5A5A, 16'hA5A5);
		send_item(ACT_LEAVE, '1, '1);
		send_item(ACT_LEAVE, '0, '0);
		send_item(ACT_LEAVE, '0, '0);
		send_item(ACT_LEAVE, '0, '0);
		send_item(ACT_LEAVE, '0, '0);

		// Random phases cycle through fill, blend and drain so the queue runs
		// full and empty several times.
		done = 0;
		phase = 0;
		while (done < RANDOM_ITEMS) begin
			mix = mix_t'(phase % 3);
			calm = ($urandom_range(0, 4) == 0);
			span = (mix == MIX_BLEND) ? $urandom_range(40, 100) : $urandom_range(80, 130);
			for (int i = 0; i < span && done < RANDOM_ITEMS; i++) begin
				if (done == RANDOM_ITEMS / 2) hold_request = 1'b1;
				random_item(mix);
				done++;
			end
			phase++;
		end
		req_ch.valid <= 1'b0;

		while (sb.outcomes_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d results checked: %0d joins (%0d moved, %0d full), %0d leaves (%0d empty),",
			sb.checked, sb.n_join, sb.n_reprio, sb.n_full, sb.n_leave, sb.n_empty);
		$display("%0d lookups (%0d hits), %0d unused, peak fill %0d of %0d, %0d mismatches",
			sb.n_lookup, sb.n_hit, sb.n_idle_act, sb.peak, DEPTH_DEF, sb.mismatches);
		if (sb.mismatches == 0 && sb.outcomes_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
